### hdl/gee_pkg.sv
package gee_pkg;

	localparam int TIME_BITS  = 40;
	localparam int VALUE_BITS = 16;
	localparam int CODE_BITS  = 3;
	localparam int EXT_BITS   = 16;
	localparam int NUM_DET    = 4;

	localparam logic [EXT_BITS-1:0] EXT_RESET = EXT_BITS'(300);
	localparam int WINDOW_LEN = 3;

	// stream packing
	localparam int IN_BITS      = VALUE_BITS + CODE_BITS + TIME_BITS;
	localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS     = 2 * TIME_BITS + VALUE_BITS;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

	// APB register map
	localparam int ADDR_BITS = 3;
	localparam logic REG_END_EXTENSION = 1'b0;

	typedef enum logic [1:0] {
		KIND_HIGH  = 2'd0,
		KIND_LOW   = 2'd1,
		KIND_VHIGH = 2'd2,
		KIND_VLOW  = 2'd3
	} kind_t;

	typedef logic signed [CODE_BITS-1:0] code_t;
	typedef logic [TIME_BITS-1:0]        time_t;
	typedef logic [VALUE_BITS-1:0]       value_t;

	// one closed event, ready for the output register
	typedef struct packed {
		kind_t  kind;
		time_t  ev_start;
		time_t  ev_end;
		value_t extreme;
		logic   last;
	} res_t;

	localparam code_t CODE_VHIGH = code_t'(2);
	localparam code_t CODE_VLOW  = code_t'(-2);

	function automatic logic qualifies(input kind_t kind, input code_t code);
		logic q;
		unique case (kind)
			KIND_HIGH:  q = (code > code_t'(0));
			KIND_LOW:   q = (code < code_t'(0));
			KIND_VHIGH: q = (code == CODE_VHIGH);
			KIND_VLOW:  q = (code == CODE_VLOW);
			default:    q = 1'b0;
		endcase
		return q;
	endfunction

	// high kinds keep the maximum, low kinds the minimum
	function automatic value_t pick(input kind_t kind, input value_t a, input value_t b);
		value_t r;
		if (kind == KIND_HIGH || kind == KIND_VHIGH) begin
			r = (a > b) ? a : b;
		end else begin
			r = (a < b) ? a : b;
		end
		return r;
	endfunction

	function automatic time_t sat_add(input time_t t, input logic [EXT_BITS-1:0] ext);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, t} + {{(TIME_BITS+1-EXT_BITS){1'b0}}, ext};
		return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
	endfunction

endpackage

### hdl/gee_detect.sv
module gee_detect (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  gee_pkg::value_t                  in_value,
	input  gee_pkg::code_t                   in_code,
	input  gee_pkg::time_t                   in_time,
	input  logic                             in_last,
	input  logic [gee_pkg::EXT_BITS-1:0]     end_ext,
	output logic                             res_valid,
	output gee_pkg::res_t                    res,
	input  logic                             res_take
);
	import gee_pkg::*;

	// sample history and record state
	time_t  times_q [3];
	code_t  codes_q [2];
	value_t values_q [2];
	logic [1:0] seen_q;
	logic [NUM_DET-1:0] act_q;

	// open event bookkeeping (no reset, only read while active)
	time_t  det_start_q [NUM_DET];
	time_t  det_end_q   [NUM_DET];
	value_t det_ext_q   [NUM_DET];

	// pending results: window closes drain before record-end closes
	logic [NUM_DET-1:0] pend_a_q, pend_b_q;
	time_t  rs_start_q [NUM_DET];
	time_t  rs_end_q   [NUM_DET];
	value_t rs_ext_q   [NUM_DET];

	logic [NUM_DET-1:0] act_n, close_a, close_b;
	time_t  start_n [NUM_DET];
	time_t  end_n   [NUM_DET];
	value_t ext_n   [NUM_DET];
	time_t  rstart  [NUM_DET];
	time_t  rend    [NUM_DET];
	value_t rext    [NUM_DET];
	logic   accept;

	// next detector state for the incoming sample
	always_comb begin
		kind_t k;
		logic  q0, q1, q2;
		act_n   = act_q;
		close_a = '0;
		close_b = '0;
		for (int d = 0; d < NUM_DET; d++) begin
			k = kind_t'(2'(d));
			q0 = qualifies(k, codes_q[0]);
			q1 = qualifies(k, codes_q[1]);
			q2 = qualifies(k, in_code);
			start_n[d] = det_start_q[d];
			end_n[d]   = det_end_q[d];
			ext_n[d]   = det_ext_q[d];
			if (seen_q >= 2'd2) begin
				if (!act_q[d]) begin
					if (q0 && q1 && q2) begin
						act_n[d]   = 1'b1;
						start_n[d] = times_q[1];
						end_n[d]   = in_time;
						ext_n[d]   = pick(k, pick(k, values_q[0], values_q[1]), in_value);
					end
				end else if (!q0 && !q1 && !q2) begin
					close_a[d] = 1'b1;
					act_n[d]   = 1'b0;
				end else begin
					end_n[d] = in_time;
					ext_n[d] = pick(k, det_ext_q[d], in_value);
				end
			end
			close_b[d] = in_last && act_n[d];
			// result entry: empty-window close ends at the sample before the window
			rstart[d] = close_a[d] ? det_start_q[d] : start_n[d];
			rend[d]   = sat_add(close_a[d] ? times_q[0] : end_n[d], end_ext);
			rext[d]   = close_a[d] ? det_ext_q[d] : ext_n[d];
		end
	end

	// output selection
	logic [NUM_DET-1:0] sel_mask, sel_one;
	logic [1:0]         sel_idx;
	logic [2*NUM_DET-1:0] pend_all, pend_left;

	always_comb begin
		sel_mask = (pend_a_q != '0) ? pend_a_q : pend_b_q;
		sel_one  = sel_mask & (~sel_mask + NUM_DET'(1));
		sel_idx  = '0;
		for (int d = NUM_DET - 1; d >= 0; d--) begin
			if (sel_mask[d]) begin
				sel_idx = 2'(d);
			end
		end
		pend_all  = {pend_b_q, pend_a_q};
		pend_left = (pend_a_q != '0) ? {pend_b_q, pend_a_q & ~sel_one}
		                             : {pend_b_q & ~sel_one, pend_a_q};
	end

	assign res_valid      = (pend_all != '0);
	assign res.kind       = kind_t'(sel_idx);
	assign res.ev_start   = rs_start_q[sel_idx];
	assign res.ev_end     = rs_end_q[sel_idx];
	assign res.extreme    = rs_ext_q[sel_idx];
	assign res.last       = (pend_left == '0);

	// take a sample when nothing waits, or the last waiting result leaves now
	assign in_ready = !res_valid || (res_take && res.last);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			times_q  <= '{default: '0};
			codes_q  <= '{default: '0};
			values_q <= '{default: '0};
			seen_q   <= '0;
			act_q    <= '0;
			pend_a_q <= '0;
			pend_b_q <= '0;
		end else begin
			if (accept) begin
				pend_a_q <= close_a;
				pend_b_q <= close_b;
				if (in_last) begin
					times_q  <= '{default: '0};
					codes_q  <= '{default: '0};
					values_q <= '{default: '0};
					seen_q   <= '0;
					act_q    <= '0;
				end else begin
					times_q[0]  <= times_q[1];
					times_q[1]  <= times_q[2];
					times_q[2]  <= in_time;
					codes_q[0]  <= codes_q[1];
					codes_q[1]  <= in_code;
					values_q[0] <= values_q[1];
					values_q[1] <= in_value;
					if (seen_q != 2'(WINDOW_LEN)) begin
						seen_q <= seen_q + 2'd1;
					end
					act_q <= act_n;
				end
			end else if (res_take) begin
				pend_a_q <= pend_left[NUM_DET-1:0];
				pend_b_q <= pend_left[2*NUM_DET-1:NUM_DET];
			end
		end
	end

	// event payload
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int d = 0; d < NUM_DET; d++) begin
				det_start_q[d] <= start_n[d];
				det_end_q[d]   <= end_n[d];
				det_ext_q[d]   <= ext_n[d];
				rs_start_q[d]  <= rstart[d];
				rs_end_q[d]    <= rend[d];
				rs_ext_q[d]    <= rext[d];
			end
		end
	end

endmodule

### hdl/glucose_excursion_event_detector.sv
// Each result passes the detector's pending registers, then the output register that drives m_tvalid.
// Throughput: one sample per cycle while no events wait; a sample that closes k events holds
// s_tready low until the last of them is taken, since the output port carries one event per cycle.
// Reset: arst_n clears history, detectors and waiting events at once;
// end_extension returns to 300.
module glucose_excursion_event_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata: glucose_value, range_code, sample_time, zero pad
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gee_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic                                s_tlast,
	// m_tdata: event start, event end, extreme_value; m_tuser: event_kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gee_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [1:0]                          m_tuser,
	output logic                                m_tlast,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gee_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import gee_pkg::*;

	logic [EXT_BITS-1:0] end_ext_q;
	logic                reg_sel;

	// configuration register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_BITS-1] == REG_END_EXTENSION);
	assign prdata  = reg_sel ? {{(32-EXT_BITS){1'b0}}, end_ext_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_ext_q <= EXT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			end_ext_q <= pwdata[EXT_BITS-1:0];
		end
	end

	// input unpacking
	value_t in_value;
	code_t  in_code;
	time_t  in_time;

	assign in_value = s_tdata[VALUE_BITS-1:0];
	assign in_code  = s_tdata[VALUE_BITS+CODE_BITS-1:VALUE_BITS];
	assign in_time  = s_tdata[IN_BITS-1:VALUE_BITS+CODE_BITS];

	logic res_valid, res_take;
	res_t res;

	gee_detect u_detect (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (in_value),
		.in_code  (in_code),
		.in_time  (in_time),
		.in_last  (s_tlast),
		.end_ext  (end_ext_q),
		.res_valid(res_valid),
		.res      (res),
		.res_take (res_take)
	);

	// output register
	logic m_valid_q;
	res_t out_q;

	assign res_take = res_valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = OUT_TDATA_W'({out_q.extreme, out_q.ev_end, out_q.ev_start});

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import gee_pkg::*;

	localparam time_t TIME_TOP      = {TIME_BITS{1'b1}};
	localparam int    SETTLE_CYCLES = 8;
	localparam int    TIMEOUT_NS    = 1000000;
	localparam int    PHASE_ITEMS   = 90;
	localparam int    NUM_PHASES    = 5;
	localparam int    NUM_PROBES    = 26;

	// range classes, including the unused encodings
	localparam code_t RC_ODD_LOW4 = code_t'(-4);
	localparam code_t RC_ODD_LOW3 = code_t'(-3);
	localparam code_t RC_VLOW     = CODE_VLOW;
	localparam code_t RC_LOW      = code_t'(-1);
	localparam code_t RC_OK       = code_t'(0);
	localparam code_t RC_HIGH     = code_t'(1);
	localparam code_t RC_VHIGH    = CODE_VHIGH;
	localparam code_t RC_ODD_HIGH = code_t'(3);

	// register map
	localparam logic [ADDR_BITS-1:0] ADDR_END_EXT = ADDR_BITS'({REG_END_EXTENSION, 2'b00});
	localparam logic [ADDR_BITS-1:0] ADDR_SPARE   = ADDR_BITS'(4);

	// one row of the directed table; ev is only used when typed_in and has_event are set
	typedef struct packed {
		value_t v;
		code_t  code;
		time_t  t;
		logic   last;
		logic   typed_in;
		logic   has_event;
		res_t   ev;
	} probe_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_BITS-1:0]   paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;

	glucose_excursion_event_detector dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	int   err_count;
	int   items_sent;
	bit   idle_on;
	res_t due_events [$];

	// mirror of the detector state
	logic [EXT_BITS-1:0] ext_setting;
	code_t               win_code [2];
	value_t              win_value [2];
	time_t               win_time [3];
	int                  fill;
	bit                  open_flag [NUM_DET];
	time_t               open_start [NUM_DET];
	time_t               open_end [NUM_DET];
	value_t              open_peak [NUM_DET];

	// count a failure; true while it should still be printed
	function automatic bit count_fault();
		err_count++;
		return err_count <= 10;
	endfunction

	function automatic int in_band(kind_t k, code_t code);
		int hit;
		case (k)
			KIND_HIGH:  hit = (code > 0) ? 1 : 0;
			KIND_LOW:   hit = (code < 0) ? 1 : 0;
			KIND_VHIGH: hit = (code == RC_VHIGH) ? 1 : 0;
			default:    hit = (code == RC_VLOW) ? 1 : 0;
		endcase
		return hit;
	endfunction

	// running max for high kinds, min for low kinds
	function automatic value_t peak_of(kind_t k, value_t a, value_t b);
		if (k == KIND_HIGH || k == KIND_VHIGH) begin
			return (a > b) ? a : b;
		end
		return (a < b) ? a : b;
	endfunction

	// end time plus extension, clipped at the top of the time range
	function automatic time_t padded_end(time_t e);
		time_t ext;
		ext = time_t'(ext_setting);
		if (e > TIME_TOP - ext) begin
			return TIME_TOP;
		end
		return e + ext;
	endfunction

	function automatic res_t closed_event(kind_t k, time_t s, time_t e, value_t x);
		res_t r;
		r.kind     = k;
		r.ev_start = s;
		r.ev_end   = padded_end(e);
		r.extreme  = x;
		r.last     = 1'b0;
		return r;
	endfunction

	function automatic probe_t probe(value_t v, code_t code, time_t t, logic last,
			logic typed_in, logic has_event, kind_t k, time_t s, time_t e, value_t x);
		probe_t r;
		r.v           = v;
		r.code        = code;
		r.t           = t;
		r.last        = last;
		r.typed_in    = typed_in;
		r.has_event   = has_event;
		r.ev.kind     = k;
		r.ev.ev_start = s;
		r.ev.ev_end   = e;
		r.ev.extreme  = x;
		r.ev.last     = 1'b1;
		return r;
	endfunction

	task automatic clear_record();
		for (int i = 0; i < 2; i++) begin
			win_code[i]  = RC_OK;
			win_value[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			win_time[i] = '0;
		end
		fill = 0;
		for (int d = 0; d < NUM_DET; d++) begin
			open_flag[d]  = 1'b0;
			open_start[d] = '0;
			open_end[d]   = '0;
			open_peak[d]  = '0;
		end
	endtask

	// advance the detector mirror by one sample; queue the closed events when keep is set
	task automatic track_excursions(input value_t v, input code_t code, input time_t t,
			input logic last, input bit keep);
		res_t  found [4];
		int    n;
		int    hits;
		kind_t k;
		n = 0;
		if (fill >= 2) begin
			for (int d = 0; d < NUM_DET; d++) begin
				k    = kind_t'(d);
				hits = in_band(k, win_code[0]) + in_band(k, win_code[1]) + in_band(k, code);
				if (!open_flag[d]) begin
					if (hits == 3) begin
						open_flag[d]  = 1'b1;
						open_start[d] = win_time[1];
						open_end[d]   = t;
						open_peak[d]  = peak_of(k, peak_of(k, win_value[0], win_value[1]), v);
					end
				end else if (hits == 0) begin
					// empty window: event ends at the sample before it
					found[n] = closed_event(k, open_start[d], win_time[0], open_peak[d]);
					n++;
					open_flag[d] = 1'b0;
				end else begin
					open_end[d]  = t;
					open_peak[d] = peak_of(k, open_peak[d], v);
				end
			end
		end

		win_time[0]  = win_time[1];
		win_time[1]  = win_time[2];
		win_time[2]  = t;
		win_code[0]  = win_code[1];
		win_code[1]  = code;
		win_value[0] = win_value[1];
		win_value[1] = v;
		if (fill < 3) begin
			fill++;
		end

		// end of record flushes every open event
		if (last) begin
			for (int d = 0; d < NUM_DET; d++) begin
				if (open_flag[d]) begin
					found[n] = closed_event(kind_t'(d), open_start[d], open_end[d], open_peak[d]);
					n++;
				end
			end
			clear_record();
		end

		if (n > 0) begin
			found[n-1].last = 1'b1;
		end
		if (keep) begin
			for (int i = 0; i < n; i++) begin
				due_events.insert(due_events.size(), found[i]);
			end
		end
	endtask

	// one sample request on the stream input, with a random idle burst ahead of it
	task automatic send_sample(input value_t v, input code_t code, input time_t t,
			input logic last, input bit keep);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({t, code, v});
		s_tlast  <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		track_excursions(v, code, t, last, keep);
	endtask

	// a record of runs of one range class, with stray codes mixed in
	task automatic random_record(input int len, input bit near_top);
		time_t  t;
		code_t  regime;
		code_t  code;
		value_t v;
		int     hold;
		t      = near_top ? TIME_TOP - time_t'($urandom_range(0, 20000))
		                  : time_t'({$urandom(), $urandom()});
		hold   = 0;
		regime = RC_OK;
		for (int i = 0; i < len; i++) begin
			if (hold == 0) begin
				regime = code_t'($urandom_range(0, 7));
				hold   = $urandom_range(2, 9);
			end
			hold--;
			code = ($urandom_range(0, 5) == 0) ? code_t'($urandom_range(0, 7)) : regime;
			case ($urandom_range(0, 9))
				0:       v = '0;
				1:       v = '1;
				2, 3, 4: v = value_t'($urandom());
				default: v = value_t'($urandom_range(200, 2500));
			endcase
			send_sample(v, code, t, (i == len - 1), 1'b1);
			items_sent++;
			if ($urandom_range(0, 9) == 0) begin
				t = t + time_t'($urandom_range(0, 5000));
			end else begin
				t = t + time_t'($urandom_range(240, 360));
			end
		end
	endtask

	// wait until every expected event is out and the pipeline is quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup phase, then access phase until pready; psel is released afterwards
	task automatic apb_access(input logic wr, input logic [ADDR_BITS-1:0] addr,
			input logic [31:0] data, output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_extension();
		logic [31:0] rd;
		apb_access(1'b0, ADDR_END_EXT, '0, rd);
		if (rd[EXT_BITS-1:0] !== ext_setting && count_fault()) begin
			$display("ERROR: end_extension read %h, expected %h", rd[EXT_BITS-1:0], ext_setting);
		end
	endtask

	task automatic set_extension(input logic [EXT_BITS-1:0] val);
		logic [31:0] rd;
		apb_access(1'b1, ADDR_END_EXT, 32'(val), rd);
		ext_setting = val;
		// unmapped address: the write must not land anywhere
		apb_access(1'b1, ADDR_SPARE, ~32'(val), rd);
		check_extension();
	endtask

	// output side: compare each event, stall in random bursts
	initial begin : event_sink
		res_t got;
		res_t want;
		int   stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got.kind     = kind_t'(m_tuser);
				got.ev_start = m_tdata[TIME_BITS-1:0];
				got.ev_end   = m_tdata[2*TIME_BITS-1:TIME_BITS];
				got.extreme  = m_tdata[2*TIME_BITS+VALUE_BITS-1:2*TIME_BITS];
				got.last     = m_tlast;
				if (due_events.size() == 0) begin
					if (count_fault()) begin
						$display("ERROR: unexpected event kind=%0d start=%h end=%h extreme=%h last=%b",
							got.kind, got.ev_start, got.ev_end, got.extreme, got.last);
					end
				end else begin
					want = due_events.pop_front();
					if (got !== want && count_fault()) begin
						$display("ERROR: expected kind=%0d start=%h end=%h extreme=%h last=%b",
							want.kind, want.ev_start, want.ev_end, want.extreme, want.last);
						$display("       got      kind=%0d start=%h end=%h extreme=%h last=%b",
							got.kind, got.ev_start, got.ev_end, got.extreme, got.last);
					end
				end
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		probe_t              probes [NUM_PROBES];
		logic [EXT_BITS-1:0] ext_plan [NUM_PHASES];
		int                  target;
		int                  len;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		idle_on     = 1'b1;
		err_count   = 0;
		items_sent  = 0;
		ext_setting = EXT_RESET;
		clear_record();

		// short record, then a record of one sample
		probes[0]  = probe(100, RC_HIGH, 0, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[1]  = probe(200, RC_HIGH, 20, 1, 1, 0, KIND_HIGH, 0, 0, 0);
		probes[2]  = probe(777, RC_VLOW, 30, 1, 1, 0, KIND_HIGH, 0, 0, 0);
		// high event flushed at the last sample, value extremes
		probes[3]  = probe(500, RC_HIGH, 100, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[4]  = probe(16'hFFFF, RC_VHIGH, 400, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[5]  = probe(0, RC_VHIGH, 700, 1, 1, 1, KIND_HIGH, 100, 1000, 16'hFFFF);
		// low and very low closed by an empty window
		probes[6]  = probe(300, RC_VLOW, 1000, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[7]  = probe(0, RC_VLOW, 1300, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[8]  = probe(200, RC_VLOW, 1600, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[9]  = probe(400, RC_OK, 1900, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[10] = probe(500, RC_OK, 2200, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[11] = probe(600, RC_OK, 2500, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		// unused codes: 3 as high only, -3 and -4 as low only
		probes[12] = probe(16'hFFFF, RC_ODD_HIGH, 2800, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[13] = probe(10, RC_HIGH, 3100, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[14] = probe(20, RC_ODD_HIGH, 3400, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[15] = probe(5, RC_ODD_LOW3, 3700, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[16] = probe(6, RC_ODD_LOW4, 4000, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[17] = probe(7, RC_LOW, 4300, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[18] = probe(8, RC_VHIGH, 4600, 1, 0, 0, KIND_HIGH, 0, 0, 0);
		// end time clipped at the top of the range
		probes[19] = probe(10, RC_HIGH, TIME_TOP - 500, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[20] = probe(20, RC_HIGH, TIME_TOP - 400, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[21] = probe(30, RC_HIGH, TIME_TOP - 100, 1, 1, 1,
			KIND_HIGH, TIME_TOP - 500, TIME_TOP, 30);
		probes[22] = probe(16'hFFFF, RC_VLOW, TIME_TOP - 2, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[23] = probe(0, RC_VLOW, TIME_TOP - 1, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[24] = probe(9, RC_VLOW, TIME_TOP, 0, 0, 0, KIND_HIGH, 0, 0, 0);
		probes[25] = probe(1, RC_OK, TIME_TOP, 1, 0, 0, KIND_HIGH, 0, 0, 0);

		ext_plan[0] = '0;
		ext_plan[1] = '1;
		ext_plan[2] = EXT_BITS'($urandom_range(1, 65534));
		ext_plan[3] = EXT_BITS'($urandom_range(1, 65534));
		ext_plan[4] = EXT_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_extension();

		// directed table, run with the reset extension
		for (int i = 0; i < NUM_PROBES; i++) begin
			send_sample(probes[i].v, probes[i].code, probes[i].t, probes[i].last,
				!probes[i].typed_in);
			if (probes[i].typed_in && probes[i].has_event) begin
				due_events.insert(due_events.size(), probes[i].ev);
			end
		end
		drain();

		// random records under several extension settings; the last phase runs flat out
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_extension(ext_plan[p]);
			if (p == NUM_PHASES - 1) begin
				idle_on = 1'b0;
			end
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
				random_record(len, $urandom_range(0, 4) == 0);
			end
			drain();
		end

		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
